[sv/vfcm_pkg.sv]
`timescale 1ns / 1ps

package vfcm_pkg;

    // Default grid and type code sizes
    localparam int CHUNK_EDGE_DEF = 16;
    localparam int TYPE_BITS_DEF  = 8;
    localparam int TYPE_BITS_MAX  = 16;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 4;
    localparam int CTYPE_W  = 8;
    localparam int DIR_W    = 3;
    localparam int VCOUNT_W = 17;

    // Vertices per emitted quad
    localparam logic [VCOUNT_W-1:0] QUAD_VERTS = VCOUNT_W'(4);

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MESH    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // Face directions, in test order
    localparam logic [DIR_W-1:0] DIR_NORTH  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_SOUTH  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_EAST   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_WEST   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_TOP    = 3'd4;
    localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd5;

endpackage

[sv/vfcm_ram.sv]
`timescale 1ns / 1ps

// Single-port RAM, registered read
module vfcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/voxel_face_culling_mesher.sv]
`timescale 1ns / 1ps

// Voxel chunk face-culling mesher. Keeps a CHUNK_EDGE^3 grid of type codes in a
// single-port RAM. s_tuser selects the operation: write a cell, mesh a cell, or
// restart (clear the vertex counter). Meshing a solid cell emits one m_ word per
// exposed face, in the order north, south, east, west, top, bottom, each with a
// base vertex that then steps by 4; m_tlast marks the cell's final face. Cells
// outside the grid count as air; every cell must be written before it is meshed.
// The block takes one word at a time; a mesh also waits on any m_tready stall, since
// the cell read and each of the six neighbor reads share the one RAM port (each
// neighbor takes an address state, then a test state). An air cell ends the mesh
// after the cell read; an out-of-grid mesh ends in the dispatch state.
module voxel_face_culling_mesher #(
    parameter int CHUNK_EDGE = vfcm_pkg::CHUNK_EDGE_DEF,
    parameter int TYPE_BITS  = vfcm_pkg::TYPE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // air_type_code register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // x_pos[3:0], y_pos[7:4], z_pos[11:8], cell_type[19:12]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // face_dir[2:0], face_type[10:3], face_x[14:11],
                                   // face_y[18:15], face_z[22:19], base_vertex[39:23]
    output logic        m_tlast    // last_face
);

    localparam int CELLS  = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int NC_W   = vfcm_pkg::COORD_W + 1;

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_RD_CELL  = 3'd2;
    localparam logic [2:0] ST_NBR_ADDR = 3'd3;
    localparam logic [2:0] ST_RESOLVE  = 3'd4;
    localparam logic [2:0] ST_FLUSH    = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [vfcm_pkg::FUNC_W-1:0]   func_reg;
    logic [vfcm_pkg::COORD_W-1:0]  x_reg, y_reg, z_reg;
    logic [vfcm_pkg::CTYPE_W-1:0]  ctype_reg;
    logic [7:0]                    air_reg;
    logic [TYPE_BITS-1:0]          own_reg, own_next;
    logic [vfcm_pkg::DIR_W-1:0]    dir_reg, dir_next;
    logic                          outside_reg, outside_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [vfcm_pkg::DIR_W-1:0]    pend_dir_reg, pend_dir_next;
    logic [vfcm_pkg::VCOUNT_W-1:0] vcnt_reg, vcnt_next;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic                   s_accept;
    logic                   out_free;
    logic                   push;
    logic                   push_last;
    logic [vfcm_pkg::DIR_W-1:0] push_dir;

    logic                   ram_en, ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [TYPE_BITS-1:0]   ram_wdata, ram_rdata;

    logic [vfcm_pkg::TYPE_BITS_MAX-1:0] air16, ctype16, own16;
    logic [TYPE_BITS-1:0]   air_code;
    logic                   rdata_air;
    logic                   cell_inside;

    logic [NC_W-1:0]        nx, ny, nz;
    logic                   nbr_outside;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Type code masking to TYPE_BITS
    assign air16     = vfcm_pkg::TYPE_BITS_MAX'(air_reg);
    assign ctype16   = vfcm_pkg::TYPE_BITS_MAX'(ctype_reg);
    assign own16     = vfcm_pkg::TYPE_BITS_MAX'(own_reg);
    assign air_code  = air16[TYPE_BITS-1:0];
    assign ram_wdata = ctype16[TYPE_BITS-1:0];
    assign rdata_air = (ram_rdata == air_code);

    assign cell_inside = (32'(x_reg) < CHUNK_EDGE) && (32'(y_reg) < CHUNK_EDGE) &&
                         (32'(z_reg) < CHUNK_EDGE);

    // Shared address unit: own cell in DISPATCH, neighbor of dir_reg otherwise
    always_comb begin
        nx = NC_W'(x_reg);
        ny = NC_W'(y_reg);
        nz = NC_W'(z_reg);
        nbr_outside = 1'b0;
        if (state_reg != ST_DISPATCH) begin
            unique case (dir_reg)
                vfcm_pkg::DIR_NORTH: begin
                    nz = nz - NC_W'(1);
                    nbr_outside = (z_reg == '0);
                end
                vfcm_pkg::DIR_SOUTH: begin
                    nz = nz + NC_W'(1);
                    nbr_outside = (32'(z_reg) == CHUNK_EDGE - 1);
                end
                vfcm_pkg::DIR_EAST: begin
                    nx = nx + NC_W'(1);
                    nbr_outside = (32'(x_reg) == CHUNK_EDGE - 1);
                end
                vfcm_pkg::DIR_WEST: begin
                    nx = nx - NC_W'(1);
                    nbr_outside = (x_reg == '0);
                end
                vfcm_pkg::DIR_TOP: begin
                    ny = ny + NC_W'(1);
                    nbr_outside = (32'(y_reg) == CHUNK_EDGE - 1);
                end
                vfcm_pkg::DIR_BOTTOM: begin
                    ny = ny - NC_W'(1);
                    nbr_outside = (y_reg == '0);
                end
                default: begin
                    nbr_outside = 1'b1;
                end
            endcase
        end
        ram_addr = ADDR_W'(32'(nx) * (CHUNK_EDGE * CHUNK_EDGE) +
                           32'(nz) * CHUNK_EDGE + 32'(ny));
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        own_next        = own_reg;
        dir_next        = dir_reg;
        outside_next    = outside_reg;
        pend_valid_next = pend_valid_reg;
        pend_dir_next   = pend_dir_reg;
        vcnt_next       = vcnt_reg;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;
        push_dir        = pend_dir_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_IDLE;
                case (func_reg)
                    vfcm_pkg::FUNC_WRITE: begin
                        ram_en = cell_inside;
                        ram_we = cell_inside;
                    end
                    vfcm_pkg::FUNC_MESH: begin
                        if (cell_inside) begin
                            ram_en     = 1'b1;
                            state_next = ST_RD_CELL;
                        end
                    end
                    vfcm_pkg::FUNC_RESTART: begin
                        vcnt_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RD_CELL: begin
                if (rdata_air) begin
                    state_next = ST_IDLE;
                end else begin
                    own_next        = ram_rdata;
                    dir_next        = vfcm_pkg::DIR_NORTH;
                    pend_valid_next = 1'b0;
                    state_next      = ST_NBR_ADDR;
                end
            end
            ST_NBR_ADDR: begin
                ram_en       = !nbr_outside;
                outside_next = nbr_outside;
                state_next   = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                // a newly found face releases the one held back before it
                if ((outside_reg || rdata_air) && pend_valid_reg && !out_free) begin
                    state_next = ST_RESOLVE;
                end else begin
                    if (outside_reg || rdata_air) begin
                        if (pend_valid_reg) begin
                            push      = 1'b1;
                            vcnt_next = vcnt_reg + vfcm_pkg::QUAD_VERTS;
                        end
                        pend_valid_next = 1'b1;
                        pend_dir_next   = dir_reg;
                    end
                    if (dir_reg == vfcm_pkg::DIR_BOTTOM) begin
                        state_next = ST_FLUSH;
                    end else begin
                        dir_next   = dir_reg + vfcm_pkg::DIR_W'(1);
                        state_next = ST_NBR_ADDR;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    vcnt_next       = vcnt_reg + vfcm_pkg::QUAD_VERTS;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    vfcm_ram #(
        .WIDTH (TYPE_BITS),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            vcnt_reg       <= '0;
            air_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            vcnt_reg       <= vcnt_next;
            if (cfg_we) begin
                air_reg <= cfg_wdata;
            end
            if (push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item and work registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg  <= s_tuser;
            x_reg     <= s_tdata[3:0];
            y_reg     <= s_tdata[7:4];
            z_reg     <= s_tdata[11:8];
            ctype_reg <= s_tdata[19:12];
        end
        own_reg      <= own_next;
        dir_reg      <= dir_next;
        outside_reg  <= outside_next;
        pend_dir_reg <= pend_dir_next;
        if (push) begin
            m_tdata_reg <= {vcnt_reg, z_reg, y_reg, x_reg, own16[7:0], push_dir};
            m_tlast_reg <= push_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // Busy right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken again right after accept");

    // Each emitted face advances the vertex counter by one quad
    a_vcnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> vcnt_reg == $past(vcnt_reg) + vfcm_pkg::QUAD_VERTS)
        else $error("vertex counter did not step by a quad");

    // Emitted base vertex is the counter value before the step
    a_base_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_tdata[39:23] == $past(vcnt_reg))
        else $error("base vertex mismatch");

    // Final face of a cell ends the mesh operation
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_last |=> state_reg == ST_IDLE && !pend_valid_reg)
        else $error("sequencer still busy after last face");

    // A held face only exists while walking the neighbors
    a_pend_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> state_reg == ST_NBR_ADDR || state_reg == ST_RESOLVE ||
                           state_reg == ST_FLUSH)
        else $error("held face outside neighbor walk");
`endif

endmodule
